[design/dns_answer_record_parser_unit_defines.svh]
// Assertion macros shared by the DNS answer record parser RTL.
// Depends on nothing; files that use it provide clk_i and rst_ni.
`ifndef DNS_ANSWER_RECORD_PARSER_UNIT_DEFINES_SVH
`define DNS_ANSWER_RECORD_PARSER_UNIT_DEFINES_SVH

// Concurrent check sampled on the rising clock, idle while reset is held.
`define DNSARP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Implication check with the same clocking and reset handling.
`define DNSARP_ASSERT_IMPLY(label, ante, cons, msg) \
  `DNSARP_ASSERT(label, (ante) |-> (cons), msg)

`endif

[design/dnsarp_pkg.sv]
// Types and constants for the DNS answer record parser.
// Depends on nothing; used by dns_answer_record_parser_unit.
package dnsarp_pkg;

  localparam int unsigned HeaderBytes = 12;
  localparam logic [7:0]  Marker      = 8'hc0;
  localparam logic [15:0] TypeA       = 16'd1;
  localparam logic [15:0] TypeCname   = 16'd5;
  localparam logic [15:0] AddrLen     = 16'd4;

  // Byte positions within a record, counted from the marker byte, and of the answer count within the header.
  localparam logic [15:0] OffTypeHi   = 16'd2;
  localparam logic [15:0] OffTypeLo   = 16'd3;
  localparam logic [15:0] OffClassHi  = 16'd4;
  localparam logic [15:0] OffClassLo  = 16'd5;
  localparam logic [15:0] OffTtlFirst = 16'd6;
  localparam logic [15:0] OffTtlLast  = 16'd9;
  localparam logic [15:0] OffLenHi    = 16'd10;
  localparam logic [15:0] OffLenLo    = 16'd11;
  localparam logic [15:0] OffCountHi  = 16'd6;
  localparam logic [15:0] OffCountLo  = 16'd7;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_HUNT   = 5'b00010,
    PH_FIELDS = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_IDLE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [15:0] record_type;
    logic [15:0] record_class;
    logic [31:0] record_ttl;
    logic [15:0] data_length;
    logic [31:0] ipv4_address;
    logic        is_address;
    logic        is_alias;
    logic [15:0] record_index;
  } result_t;

endpackage

[design/dns_answer_record_parser_unit.sv]
// DNS answer record parser: byte-wide message in, one decoded record out.
// Depends on dnsarp_pkg and dns_answer_record_parser_unit_defines.svh.
//
// Usage: the message enters one byte per accepted input handshake, header
// first, with last_byte_i marking its final byte. Bytes 6 and 7 of the
// header give the answer count. After the header the parser hunts for the
// 0xc0 name pointer, gathers type, class, TTL and data length, then skips
// the data, keeping the first four data bytes as an IPv4 address. Each
// completed record among the first answer-count records yields one output
// word; incomplete records at message end are dropped.
// Throughput is one byte per cycle while the output is not stalled: the
// parse state advances once per accepted byte and the result lands in one
// output register. A record appears on the output in the cycle after the byte that completes it is accepted.
// While the output word is stalled, in_ready_o stays high only when the
// output register is being drained in the same cycle. Reset, and the
// final byte of each message, return the parser to the header phase.
`include "dns_answer_record_parser_unit_defines.svh"

module dns_answer_record_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] record_type_o,
  output logic [15:0] record_class_o,
  output logic [31:0] record_ttl_o,
  output logic [15:0] data_length_o,
  output logic [31:0] ipv4_address_o,
  output logic        is_address_o,
  output logic        is_alias_o,
  output logic [15:0] record_index_o
);

  dnsarp_pkg::phase_e phase_q, phase_d;
  logic [15:0] byte_offset_q, byte_offset_d;
  logic [15:0] answer_count_q, answer_count_d;
  logic [15:0] records_done_q, records_done_d;
  logic [15:0] type_q, type_d;
  logic [15:0] class_q, class_d;
  logic [31:0] ttl_q, ttl_d;
  logic [15:0] length_q, length_d;
  logic [31:0] address_q, address_d;

  logic                out_valid_q, out_valid_d;
  dnsarp_pkg::result_t out_rec_q, out_rec_d;

  logic        accept;
  logic        emit;
  logic        addr_rec;
  logic [15:0] offset_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign offset_inc = byte_offset_q + 16'd1;

  always_comb begin
    phase_d        = phase_q;
    byte_offset_d  = byte_offset_q;
    answer_count_d = answer_count_q;
    records_done_d = records_done_q;
    type_d         = type_q;
    class_d        = class_q;
    ttl_d          = ttl_q;
    length_d       = length_q;
    address_d      = address_q;
    emit           = 1'b0;

    unique case (phase_q)
      dnsarp_pkg::PH_HEADER: begin
        if (byte_offset_q == dnsarp_pkg::OffCountHi) begin
          answer_count_d = {data_byte_i, answer_count_q[7:0]};
        end else if (byte_offset_q == dnsarp_pkg::OffCountLo) begin
          answer_count_d = {answer_count_q[15:8], data_byte_i};
        end
        byte_offset_d = offset_inc;
        if (offset_inc >= 16'(dnsarp_pkg::HeaderBytes)) begin
          byte_offset_d = '0;
          phase_d = (answer_count_d != '0) ? dnsarp_pkg::PH_HUNT : dnsarp_pkg::PH_IDLE;
        end
      end
      dnsarp_pkg::PH_HUNT: begin
        if (data_byte_i == dnsarp_pkg::Marker) begin
          phase_d       = dnsarp_pkg::PH_FIELDS;
          byte_offset_d = 16'd1;
          type_d        = '0;
          class_d       = '0;
          ttl_d         = '0;
          length_d      = '0;
          address_d     = '0;
        end
      end
      dnsarp_pkg::PH_FIELDS: begin
        if (byte_offset_q == dnsarp_pkg::OffTypeHi ||
            byte_offset_q == dnsarp_pkg::OffTypeLo) begin
          type_d = {type_q[7:0], data_byte_i};
        end else if (byte_offset_q == dnsarp_pkg::OffClassHi ||
                     byte_offset_q == dnsarp_pkg::OffClassLo) begin
          class_d = {class_q[7:0], data_byte_i};
        end else if (byte_offset_q >= dnsarp_pkg::OffTtlFirst &&
                     byte_offset_q <= dnsarp_pkg::OffTtlLast) begin
          ttl_d = {ttl_q[23:0], data_byte_i};
        end else if (byte_offset_q == dnsarp_pkg::OffLenHi ||
                     byte_offset_q == dnsarp_pkg::OffLenLo) begin
          length_d = {length_q[7:0], data_byte_i};
        end
        if (byte_offset_q >= dnsarp_pkg::OffLenLo) begin
          byte_offset_d = '0;
          // A record with no data completes on its second length byte.
          if (length_d == '0) begin
            emit = 1'b1;
          end else begin
            phase_d = dnsarp_pkg::PH_DATA;
          end
        end else begin
          byte_offset_d = offset_inc;
        end
      end
      dnsarp_pkg::PH_DATA: begin
        if (byte_offset_q < dnsarp_pkg::AddrLen) begin
          address_d = {address_q[23:0], data_byte_i};
        end
        byte_offset_d = offset_inc;
        if (offset_inc >= length_q) begin
          emit = 1'b1;
        end
      end
      dnsarp_pkg::PH_IDLE: begin
      end
      default: begin
      end
    endcase

    if (emit) begin
      records_done_d = records_done_q + 16'd1;
      byte_offset_d  = '0;
      phase_d = (records_done_d < answer_count_d) ? dnsarp_pkg::PH_HUNT :
                                                    dnsarp_pkg::PH_IDLE;
    end

    if (last_byte_i) begin
      phase_d        = dnsarp_pkg::PH_HEADER;
      byte_offset_d  = '0;
      answer_count_d = '0;
      records_done_d = '0;
      type_d         = '0;
      class_d        = '0;
      ttl_d          = '0;
      length_d       = '0;
      address_d      = '0;
    end
  end

  assign addr_rec = (type_d == dnsarp_pkg::TypeA) && (length_d == dnsarp_pkg::AddrLen);

  always_comb begin
    out_rec_d.record_type  = type_d;
    out_rec_d.record_class = class_d;
    out_rec_d.record_ttl   = ttl_d;
    out_rec_d.data_length  = length_d;
    out_rec_d.ipv4_address = addr_rec ? address_d : '0;
    out_rec_d.is_address   = addr_rec;
    out_rec_d.is_alias     = (type_d == dnsarp_pkg::TypeCname);
    out_rec_d.record_index = records_done_q;
    // The holds are cleared by the last byte, so take them before that.
    if (last_byte_i) begin
      out_rec_d.record_type  = type_q;
      out_rec_d.record_class = class_q;
      out_rec_d.record_ttl   = ttl_q;
      out_rec_d.data_length  = length_q;
      out_rec_d.ipv4_address = '0;
      out_rec_d.is_address   = 1'b0;
      out_rec_d.is_alias     = 1'b0;
    end
    if (accept) begin
      out_valid_d = emit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Record fields as they stand after this byte, ignoring the reset that a
  // final byte applies; used when the record completes on the last byte.
  logic [15:0] rec_type, rec_class, rec_len;
  logic [31:0] rec_ttl, rec_addr;
  logic        rec_addr_ok;

  always_comb begin
    rec_type  = type_q;
    rec_class = class_q;
    rec_ttl   = ttl_q;
    rec_len   = length_q;
    rec_addr  = address_q;
    if (phase_q == dnsarp_pkg::PH_FIELDS) begin
      if (byte_offset_q == dnsarp_pkg::OffLenLo) begin
        rec_len = {length_q[7:0], data_byte_i};
      end
    end else if (phase_q == dnsarp_pkg::PH_DATA) begin
      if (byte_offset_q < dnsarp_pkg::AddrLen) begin
        rec_addr = {address_q[23:0], data_byte_i};
      end
    end
    rec_addr_ok = (rec_type == dnsarp_pkg::TypeA) && (rec_len == dnsarp_pkg::AddrLen);
  end

  dnsarp_pkg::result_t out_rec_sel;

  always_comb begin
    out_rec_sel = out_rec_d;
    if (last_byte_i) begin
      out_rec_sel.record_type  = rec_type;
      out_rec_sel.record_class = rec_class;
      out_rec_sel.record_ttl   = rec_ttl;
      out_rec_sel.data_length  = rec_len;
      out_rec_sel.ipv4_address = rec_addr_ok ? rec_addr : '0;
      out_rec_sel.is_address   = rec_addr_ok;
      out_rec_sel.is_alias     = (rec_type == dnsarp_pkg::TypeCname);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= dnsarp_pkg::PH_HEADER;
      byte_offset_q  <= '0;
      answer_count_q <= '0;
      records_done_q <= '0;
      type_q         <= '0;
      class_q        <= '0;
      ttl_q          <= '0;
      length_q       <= '0;
      address_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q        <= phase_d;
        byte_offset_q  <= byte_offset_d;
        answer_count_q <= answer_count_d;
        records_done_q <= records_done_d;
        type_q         <= type_d;
        class_q        <= class_d;
        ttl_q          <= ttl_d;
        length_q       <= length_d;
        address_q      <= address_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_rec_q <= out_rec_sel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_type_o  = out_rec_q.record_type;
  assign record_class_o = out_rec_q.record_class;
  assign record_ttl_o   = out_rec_q.record_ttl;
  assign data_length_o  = out_rec_q.data_length;
  assign ipv4_address_o = out_rec_q.ipv4_address;
  assign is_address_o   = out_rec_q.is_address;
  assign is_alias_o     = out_rec_q.is_alias;
  assign record_index_o = out_rec_q.record_index;

  `DNSARP_ASSERT(a_last_resets,
    (accept && last_byte_i) |=> (phase_q == dnsarp_pkg::PH_HEADER &&
      byte_offset_q == '0 && records_done_q == '0),
    "final byte did not return the parser to the header phase")
  `DNSARP_ASSERT_IMPLY(a_data_nonzero, phase_q == dnsarp_pkg::PH_DATA,
    length_q != '0, "data phase entered with zero data length")
  `DNSARP_ASSERT_IMPLY(a_hunt_count, phase_q == dnsarp_pkg::PH_HUNT,
    records_done_q < answer_count_q, "hunting beyond the answer count")
  `DNSARP_ASSERT_IMPLY(a_fields_offset, phase_q == dnsarp_pkg::PH_FIELDS,
    byte_offset_q >= 16'd1 && byte_offset_q <= dnsarp_pkg::OffLenLo,
    "field byte offset out of range")

endmodule
